[sv/vfce_pkg.sv]
// ----------------------------------------------------------------------------
// vfce_pkg
// Shared types, face codes and the corner offset table for the voxel face
// cull emitter.
// ----------------------------------------------------------------------------
package vfce_pkg;

    localparam int unsigned CNT_W    = 20;
    localparam int unsigned COORD_W  = 5;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned FACE_N   = 6;

    typedef enum logic [2:0] {
        FACE_PX = 3'd0,
        FACE_NX = 3'd1,
        FACE_PY = 3'd2,
        FACE_NY = 3'd3,
        FACE_PZ = 3'd4,
        FACE_NZ = 3'd5
    } face_t;

    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'd3;

    // Corner offsets packed as {x, y, z}, counter-clockwise per face.
    localparam logic [2:0] FACE_CORNER [FACE_N][4] = '{
        '{3'b100, 3'b101, 3'b111, 3'b110},
        '{3'b001, 3'b000, 3'b010, 3'b011},
        '{3'b011, 3'b010, 3'b110, 3'b111},
        '{3'b000, 3'b001, 3'b101, 3'b100},
        '{3'b101, 3'b001, 3'b011, 3'b111},
        '{3'b000, 3'b100, 3'b110, 3'b010}
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
    } vfce_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_faces;
        logic out_free;
        logic step_last;
    } vfce_status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } vfce_state_t;

    // Lowest pending face wins, which gives the +X, -X, +Y, -Y, +Z, -Z order.
    function automatic face_t first_face(input logic [FACE_N-1:0] mask);
        face_t f;
        f = FACE_NZ;
        priority if (mask[0]) f = FACE_PX;
        else if (mask[1]) f = FACE_NX;
        else if (mask[2]) f = FACE_PY;
        else if (mask[3]) f = FACE_NY;
        else if (mask[4]) f = FACE_PZ;
        else f = FACE_NZ;
        return f;
    endfunction

endpackage

[sv/vfce_ctrl.sv]
// ----------------------------------------------------------------------------
// vfce_ctrl
// Controller: takes one voxel at a time and paces vertex emission.
// ----------------------------------------------------------------------------
module vfce_ctrl
    import vfce_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  vfce_status_t status,
    output vfce_cmd_t    cmd
);

    vfce_state_t state_reg;
    vfce_state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);
    assign cmd.load = in_ready & in_valid;
    assign cmd.step = (state_reg == ST_EMIT) & status.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.has_faces)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.step && status.step_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/vfce_dp.sv]
// ----------------------------------------------------------------------------
// vfce_dp
// Datapath: voxel registers, pending face mask, corner and vertex counters,
// and the output register.
// ----------------------------------------------------------------------------
module vfce_dp
    import vfce_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  vfce_cmd_t           cmd,
    output vfce_status_t        status,
    input  logic                chunk_start,
    input  logic [COORD_W-1:0]  vox_x,
    input  logic [COORD_W-1:0]  vox_y,
    input  logic [COORD_W-1:0]  vox_z,
    input  logic                self_solid,
    input  logic [FACE_N-1:0]   neighbor_solid,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [POS_W-1:0]    pos_x,
    output logic [POS_W-1:0]    pos_y,
    output logic [POS_W-1:0]    pos_z,
    output logic [1:0]          uv_corner,
    output logic [2:0]          face_dir,
    output logic [CNT_W-1:0]    face_base,
    output logic [CNT_W-1:0]    vertex_index,
    output logic                last
);

    logic [COORD_W-1:0] vx_reg, vy_reg, vz_reg;
    logic [FACE_N-1:0]  mask_reg, mask_next;
    logic [1:0]         corner_reg, corner_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;

    logic [POS_W-1:0]   pos_x_reg, pos_y_reg, pos_z_reg;
    logic [1:0]         uv_reg;
    logic [2:0]         face_reg;
    logic [CNT_W-1:0]   base_reg, index_reg;
    logic               last_reg;

    logic [FACE_N-1:0]  load_mask;
    face_t              cur_face;
    logic [2:0]         offs;
    logic               single_face;

    assign load_mask   = ~neighbor_solid & {FACE_N{self_solid}};
    assign cur_face    = first_face(mask_reg);
    assign offs        = FACE_CORNER[cur_face][corner_reg];
    assign single_face = ((mask_reg & (mask_reg - 1'b1)) == '0);

    assign status.has_faces = (load_mask != '0);
    assign status.out_free  = ~out_valid_reg | out_ready;
    assign status.step_last = (corner_reg == CORNER_LAST) & single_face;

    always_comb
    begin
        mask_next      = mask_reg;
        corner_next    = corner_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        if (cmd.load)
        begin
            mask_next   = load_mask;
            corner_next = CORNER_FIRST;
            if (chunk_start)
            begin
                count_next = '0;
            end
        end
        else if (cmd.step)
        begin
            out_valid_next = 1'b1;
            count_next     = count_reg + 1'b1;
            corner_next    = corner_reg + 1'b1;
            if (corner_reg == CORNER_LAST)
            begin
                mask_next = mask_reg & (mask_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            corner_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            corner_reg    <= corner_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vx_reg <= vox_x;
            vy_reg <= vox_y;
            vz_reg <= vox_z;
        end
        if (cmd.step)
        begin
            pos_x_reg <= {1'b0, vx_reg} + {{(POS_W-1){1'b0}}, offs[2]};
            pos_y_reg <= {1'b0, vy_reg} + {{(POS_W-1){1'b0}}, offs[1]};
            pos_z_reg <= {1'b0, vz_reg} + {{(POS_W-1){1'b0}}, offs[0]};
            uv_reg    <= corner_reg;
            face_reg  <= cur_face;
            base_reg  <= count_reg - {{(CNT_W-2){1'b0}}, corner_reg};
            index_reg <= count_reg;
            last_reg  <= status.step_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign pos_z        = pos_z_reg;
    assign uv_corner    = uv_reg;
    assign face_dir     = face_reg;
    assign face_base    = base_reg;
    assign vertex_index = index_reg;
    assign last         = last_reg;

endmodule

[sv/voxel_face_cull_emitter_unit.sv]
// ----------------------------------------------------------------------------
// voxel_face_cull_emitter_unit
// Naive face-culling voxel mesher: one voxel in, four vertices out for each
// exposed face of a solid voxel.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake           | Beat carries
//  --------+---------------------+-----------------------------------------
//  in      | in_valid / in_ready | one voxel: chunk_start, coordinates,
//          |                     | self_solid, neighbor_solid
//  out     | out_valid/out_ready | one vertex: position, uv_corner, face_dir,
//          |                     | face_base, vertex_index, last
//
//  A voxel is accepted in the idle state, then one vertex is emitted per cycle
//  while the output side keeps taking beats. The vertex emitter handles one
//  voxel at a time; the output register lets the next voxel be accepted while
//  the final vertex still waits. A stalled output holds the emitter.
//  Reset clears the controller, the output valid and the vertex counter.
//
module voxel_face_cull_emitter_unit
    import vfce_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                chunk_start,
    input  logic [COORD_W-1:0]  vox_x,
    input  logic [COORD_W-1:0]  vox_y,
    input  logic [COORD_W-1:0]  vox_z,
    input  logic                self_solid,
    input  logic [FACE_N-1:0]   neighbor_solid,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [POS_W-1:0]    pos_x,
    output logic [POS_W-1:0]    pos_y,
    output logic [POS_W-1:0]    pos_z,
    output logic [1:0]          uv_corner,
    output logic [2:0]          face_dir,
    output logic [CNT_W-1:0]    face_base,
    output logic [CNT_W-1:0]    vertex_index,
    output logic                last
);

    // The controller only sequences; all payload state lives in the datapath.
    vfce_cmd_t    cmd;
    vfce_status_t status;

    vfce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath walks the pending faces lowest first and four corners per
    // face, numbering vertices with a counter that chunk_start clears.
    vfce_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .chunk_start    (chunk_start),
        .vox_x          (vox_x),
        .vox_y          (vox_y),
        .vox_z          (vox_z),
        .self_solid     (self_solid),
        .neighbor_solid (neighbor_solid),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .uv_corner      (uv_corner),
        .face_dir       (face_dir),
        .face_base      (face_base),
        .vertex_index   (vertex_index),
        .last           (last)
    );

endmodule

[tb/vfce_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vfce_checker
// Watches both channels of the voxel face cull emitter. Each accepted voxel is
// expanded into the vertices it must produce. Each accepted vertex beat is
// compared field by field with the oldest vertex still owed.
// ----------------------------------------------------------------------------
module vfce_checker
    import vfce_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                chunk_start,
    input  logic [COORD_W-1:0]  vox_x,
    input  logic [COORD_W-1:0]  vox_y,
    input  logic [COORD_W-1:0]  vox_z,
    input  logic                self_solid,
    input  logic [FACE_N-1:0]   neighbor_solid,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [POS_W-1:0]    pos_x,
    input  logic [POS_W-1:0]    pos_y,
    input  logic [POS_W-1:0]    pos_z,
    input  logic [1:0]          uv_corner,
    input  logic [2:0]          face_dir,
    input  logic [CNT_W-1:0]    face_base,
    input  logic [CNT_W-1:0]    vertex_index,
    input  logic                last,
    output int                  vertices_owed,
    output int                  mismatch_count
);

    // Corner offsets as {x, y, z}, counter-clockwise, in face order.
    localparam logic [2:0] CORNER_OFFSET [6][4] = '{
        '{3'b100, 3'b101, 3'b111, 3'b110},
        '{3'b001, 3'b000, 3'b010, 3'b011},
        '{3'b011, 3'b010, 3'b110, 3'b111},
        '{3'b000, 3'b001, 3'b101, 3'b100},
        '{3'b101, 3'b001, 3'b011, 3'b111},
        '{3'b000, 3'b100, 3'b110, 3'b010}
    };

    typedef struct {
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [POS_W-1:0] pz;
        logic [1:0]       uv;
        face_t            face;
        logic [CNT_W-1:0] base;
        logic [CNT_W-1:0] index;
        logic             last;
    } vertex_t;

    vertex_t          vertex_q[$];
    vertex_t          oldest;
    logic [CNT_W-1:0] mesh_count;

    initial mismatch_count = 0;
    initial vertices_owed  = 0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t vfce_checker: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Expands one voxel into its owed vertices and advances the mesh counter.
    task automatic queue_vertices(
        input logic               restart,
        input logic [COORD_W-1:0] vx,
        input logic [COORD_W-1:0] vy,
        input logic [COORD_W-1:0] vz,
        input logic               solid,
        input logic [FACE_N-1:0]  covered
    );
        vertex_t          v;
        int               final_face;
        logic [CNT_W-1:0] base;

        if (restart)
            mesh_count = '0;
        if (!solid)
            return;
        final_face = -1;
        for (int f = 0; f < FACE_N; f++)
            if (!covered[f])
                final_face = f;
        for (int f = 0; f < FACE_N; f++)
        begin
            if (covered[f])
                continue;
            base = mesh_count;
            for (int c = 0; c < 4; c++)
            begin
                v.px    = POS_W'(vx) + POS_W'(CORNER_OFFSET[f][c][2]);
                v.py    = POS_W'(vy) + POS_W'(CORNER_OFFSET[f][c][1]);
                v.pz    = POS_W'(vz) + POS_W'(CORNER_OFFSET[f][c][0]);
                v.uv    = 2'(c);
                v.face  = face_t'(f);
                v.base  = base;
                v.index = mesh_count;
                v.last  = (f == final_face) && (c == 3);
                vertex_q = {vertex_q, v};
                mesh_count = mesh_count + 1'b1;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            vertex_q.delete();
            mesh_count = '0;
            vertices_owed <= 0;
        end
        else
        begin
            // The output beat is older than any voxel taken at the same edge.
            if (out_valid && out_ready)
            begin
                if (vertex_q.size() == 0)
                begin
                    report_mismatch($sformatf("vertex beat with nothing owed, index %0d",
                                              vertex_index));
                end
                else
                begin
                    oldest = vertex_q.pop_front();
                    check_field("pos_x", pos_x, oldest.px);
                    check_field("pos_y", pos_y, oldest.py);
                    check_field("pos_z", pos_z, oldest.pz);
                    check_field("uv_corner", uv_corner, oldest.uv);
                    check_field("face_dir", face_dir, oldest.face);
                    check_field("face_base", face_base, oldest.base);
                    check_field("vertex_index", vertex_index, oldest.index);
                    check_field("last", last, oldest.last);
                end
            end
            if (in_valid && in_ready)
                queue_vertices(chunk_start, vox_x, vox_y, vox_z, self_solid,
                               neighbor_solid);
            vertices_owed <= vertex_q.size();
        end
    end

endmodule

[tb/tb_voxel_face_cull_emitter_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_voxel_face_cull_emitter_unit
// Drives voxels into the face cull emitter and lets vfce_checker predict and
// compare every vertex beat. A directed opening covers coordinate extremes,
// every single exposed face, fully covered and empty voxels and chunk restarts;
// a random part follows with short scan-ordered chunk runs mixed with noise.
// ----------------------------------------------------------------------------
module tb_voxel_face_cull_emitter_unit;

    import vfce_pkg::*;

    // The run stops on its own well before this; reaching it means a hang.
    localparam int CYCLE_LIMIT  = 500000;
    // Total voxels across the directed and random parts.
    localparam int ITEM_TARGET  = 410;
    // Length of the one long output hold-off that fills the block up.
    localparam int LONG_HOLD    = 300;
    // Tail wait after the last owed vertex, longer than a fully exposed voxel needs.
    localparam int DRAIN_CYCLES = 40;

    // Ways the receiver can pace its ready signal.
    typedef enum logic [1:0] {
        RDY_ALWAYS   = 2'd0,
        RDY_COIN     = 2'd1,
        RDY_PERIODIC = 2'd2,
        RDY_MOSTLY   = 2'd3
    } ready_mode_t;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_ready;
    logic                chunk_start    = 1'b0;
    logic [COORD_W-1:0]  vox_x          = '0;
    logic [COORD_W-1:0]  vox_y          = '0;
    logic [COORD_W-1:0]  vox_z          = '0;
    logic                self_solid     = 1'b0;
    logic [FACE_N-1:0]   neighbor_solid = '0;
    logic                out_valid;
    logic                out_ready      = 1'b0;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [POS_W-1:0]    pos_z;
    logic [1:0]          uv_corner;
    logic [2:0]          face_dir;
    logic [CNT_W-1:0]    face_base;
    logic [CNT_W-1:0]    vertex_index;
    logic                last;

    int   vertices_owed;
    int   mismatch_count;
    int   cycle_count    = 0;
    int   items_sent     = 0;
    int   burst_left     = 0;
    // Raised once by the stimulus; the receiver then holds off on its own.
    logic long_hold_req  = 1'b0;

    voxel_face_cull_emitter_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .chunk_start    (chunk_start),
        .vox_x          (vox_x),
        .vox_y          (vox_y),
        .vox_z          (vox_z),
        .self_solid     (self_solid),
        .neighbor_solid (neighbor_solid),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .uv_corner      (uv_corner),
        .face_dir       (face_dir),
        .face_base      (face_base),
        .vertex_index   (vertex_index),
        .last           (last)
    );

    vfce_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .chunk_start    (chunk_start),
        .vox_x          (vox_x),
        .vox_y          (vox_y),
        .vox_z          (vox_z),
        .self_solid     (self_solid),
        .neighbor_solid (neighbor_solid),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .uv_corner      (uv_corner),
        .face_dir       (face_dir),
        .face_base      (face_base),
        .vertex_index   (vertex_index),
        .last           (last),
        .vertices_owed  (vertices_owed),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a block that stops moving ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // Neighbor masks are biased toward the interesting shapes: fully covered,
    // fully exposed and a single exposed face, with plain random masks too.
    function automatic logic [FACE_N-1:0] pick_neighbors();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return '1;
        if (roll < 35)
            return '0;
        if (roll < 50)
            return ~(FACE_N'(1) << $urandom_range(0, FACE_N - 1));
        return FACE_N'($urandom);
    endfunction

    // Presents one voxel beat and waits for it to be taken. The valid stays
    // high into the next beat while a burst lasts; at the end of a burst it
    // drops for a random gap, so the gaps land on every phase of the emitter.
    task automatic send_voxel(
        input logic               restart,
        input logic [COORD_W-1:0] vx,
        input logic [COORD_W-1:0] vy,
        input logic [COORD_W-1:0] vz,
        input logic               solid,
        input logic [FACE_N-1:0]  covered
    );
        chunk_start    <= restart;
        vox_x          <= vx;
        vox_y          <= vy;
        vox_z          <= vz;
        self_solid     <= solid;
        neighbor_solid <= covered;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
            // Now and then a long burst gives a stretch with no sender gaps.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Receiver pacing. It switches among its own patterns every so often and
    // once, when asked, refuses every beat through one long hold-off so that the
    // output register and the emitter back up into the input channel.
    initial
    begin : receiver
        ready_mode_t mode;
        int          mode_left;
        int          period;
        logic        hold_done;
        logic        ready_next;

        mode      = RDY_ALWAYS;
        mode_left = 0;
        period    = 2;
        hold_done = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold_req && !hold_done)
            begin
                for (int i = 0; i < LONG_HOLD; i++)
                begin
                    out_ready <= 1'b0;
                    @(posedge clk);
                end
                hold_done = 1'b1;
            end
            if (mode_left <= 0)
            begin
                mode      = ready_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
                period    = $urandom_range(2, 5);
            end
            case (mode)
                RDY_ALWAYS:   ready_next = 1'b1;
                RDY_COIN:     ready_next = 1'($urandom_range(0, 1));
                RDY_PERIODIC: ready_next = (mode_left % period) == 0;
                default:      ready_next = $urandom_range(0, 3) != 0;
            endcase
            out_ready <= ready_next;
            mode_left--;
            @(posedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        logic [3*COORD_W-1:0] scan;
        int                   run_len;

        burst_left = $urandom_range(1, 12);
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening. A fully exposed voxel at the origin opens a chunk,
        // then the far corner shows positions reaching 32 on every axis.
        send_voxel(1'b1, 5'd0, 5'd0, 5'd0, 1'b1, 6'h00);
        send_voxel(1'b0, 5'd31, 5'd31, 5'd31, 1'b1, 6'h00);
        // Each face exposed on its own, so every face code and corner set
        // shows up in isolation.
        for (int f = 0; f < FACE_N; f++)
            send_voxel(1'b0, 5'(3 * f), 5'(31 - f), 5'(5 * f), 1'b1,
                       ~(FACE_N'(1) << f));
        // Fully covered and empty voxels emit nothing and leave the count.
        send_voxel(1'b0, 5'd7, 5'd8, 5'd9, 1'b1, 6'h3F);
        send_voxel(1'b0, 5'd10, 5'd11, 5'd12, 1'b0, 6'h00);
        // A restart on an empty voxel still clears the counter.
        send_voxel(1'b1, 5'd1, 5'd2, 5'd3, 1'b0, 6'h15);
        send_voxel(1'b0, 5'd31, 5'd0, 5'd31, 1'b1, 6'h15);
        send_voxel(1'b0, 5'd0, 5'd31, 5'd0, 1'b1, 6'h2A);
        // A restart on a covered voxel, then one on a solid exposed voxel.
        send_voxel(1'b1, 5'd16, 5'd16, 5'd16, 1'b1, 6'h3F);
        send_voxel(1'b0, 5'd17, 5'd16, 5'd16, 1'b1, 6'h2A);
        send_voxel(1'b1, 5'd30, 5'd1, 5'd29, 1'b1, 6'h00);
        send_voxel(1'b1, 5'd31, 5'd1, 5'd29, 1'b1, 6'h00);

        // Random part: mostly short chunks scanned in x, y, z order with a
        // restart on the first voxel, interleaved with unrelated noise beats.
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= 120 && !long_hold_req)
                long_hold_req <= 1'b1;
            if ($urandom_range(0, 99) < 15)
            begin
                send_voxel(1'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                           1'($urandom), FACE_N'($urandom));
            end
            else
            begin
                run_len = $urandom_range(3, 24);
                scan    = 15'($urandom);
                for (int i = 0; i < run_len && items_sent < ITEM_TARGET; i++)
                begin
                    send_voxel(i == 0, scan[COORD_W-1:0], scan[2*COORD_W-1:COORD_W],
                               scan[3*COORD_W-1:2*COORD_W],
                               $urandom_range(0, 99) < 70, pick_neighbors());
                    scan = scan + 1'b1;
                end
            end
        end
        in_valid <= 1'b0;

        // Drain: wait for every owed vertex, then give the emitter time to
        // show any beat it should not produce.
        do
            @(posedge clk);
        while (vertices_owed != 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
